>>> rtl/quoted_argument_tokenizer_macros.svh
// Assertion macros shared by the tokenizer checker.
`ifndef QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QAT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qat assertion failed");

// Next-cycle implication, disabled during reset.
`define QAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qat assertion failed");

`endif

>>> rtl/qat_pkg.sv
// Package: types, byte codes and the escape map for the argument tokenizer.
`timescale 1ns / 1ps

package qat_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_QUOTED = 3'b010,
    MODE_ESCAPE = 3'b100
  } qat_mode_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic       token_drop;
  } qat_result_t;

  function automatic logic [7:0] qat_map_escape(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'h61:   m = 8'h07; // a
      8'h62:   m = 8'h08; // b
      8'h65:   m = 8'h1B; // e
      8'h66:   m = 8'h0C; // f
      8'h6E:   m = 8'h0A; // n
      8'h72:   m = 8'h0D; // r
      8'h74:   m = 8'h09; // t
      8'h76:   m = 8'h0B; // v
      default: m = c;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/qat_parse.sv
// Parser state and the per-byte next-state and result logic.
`timescale 1ns / 1ps

module qat_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          ch,
  input  logic                last,
  output qat_pkg::qat_result_t result
);
  import qat_pkg::*;

  qat_mode_t mode, mode_next;
  logic      plain_open, plain_open_next;

  always_comb begin
    mode_next       = mode;
    plain_open_next = plain_open;
    result          = '0;
    case (mode)
      MODE_ESCAPE: begin
        result.out_char   = qat_map_escape(ch);
        result.char_valid = 1'b1;
        mode_next         = MODE_QUOTED;
      end
      MODE_QUOTED: begin
        if (ch == CH_QUOTE) begin
          result.token_end = 1'b1;
          mode_next        = MODE_NORMAL;
        end else if (ch == CH_BSLASH) begin
          mode_next = MODE_ESCAPE;
        end else begin
          result.out_char   = ch;
          result.char_valid = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        if (ch inside {CH_SPACE, CH_QUOTE}) begin
          if (plain_open) begin
            result.token_end = 1'b1;
            plain_open_next  = 1'b0;
          end
          if (ch == CH_QUOTE) begin
            mode_next = MODE_QUOTED;
          end
        end else begin
          result.out_char   = ch;
          result.char_valid = 1'b1;
          plain_open_next   = 1'b1;
        end
      end
    endcase
    // line end closes a plain token, drops an unfinished quoted one
    if (last) begin
      if (plain_open_next) begin
        result.token_end = 1'b1;
      end
      if (mode_next != MODE_NORMAL) begin
        result.token_drop = 1'b1;
      end
      mode_next       = MODE_NORMAL;
      plain_open_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      plain_open <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      plain_open <= plain_open_next;
    end
  end

endmodule

>>> rtl/qat_out_buf.sv
// Result register with a skid stage so input ready is a registered signal.
`timescale 1ns / 1ps

module qat_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qat_pkg::qat_result_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output qat_pkg::qat_result_t out_data
);
  import qat_pkg::*;

  logic        skid_valid;
  qat_result_t skid_data;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> rtl/quoted_argument_tokenizer.sv
// An accepted word's result is registered in the output register, or in the skid entry while the master side stalls.
// Throughput: one word per cycle while s_tready is high; the parser state updates in the accepting cycle.
// A two-entry result buffer keeps s_tready registered; it drops only when both entries are full.
// Reset (rst, synchronous, active high): mode back to normal, no plain token open,
// result buffer emptied; payload registers are left as they are.
`timescale 1ns / 1ps

module quoted_argument_tokenizer (
  input  logic       clk,
  input  logic       rst,
  // slave side: command line bytes
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] ch
  input  logic       s_tlast,  // last byte of the line
  // master side: token results
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // [7:0] out_char (zero when char_valid is low)
  output logic [1:0] m_tuser,  // [0] char_valid, [1] token_drop
  output logic       m_tlast   // token_end
);
  import qat_pkg::*;

  logic        accept;
  qat_result_t step_result;
  qat_result_t out_result;

  // a word is taken whenever the buffer has room
  assign accept = s_tvalid && s_tready;

  // parser: mode and plain-token flag, next result from the current byte
  qat_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (s_tdata),
    .last   (s_tlast),
    .result (step_result)
  );

  // result register plus skid entry
  qat_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = out_result.out_char;
  assign m_tuser = {out_result.token_drop, out_result.char_valid};
  assign m_tlast = out_result.token_end;

endmodule

>>> rtl/qat_checker.sv
// Port-level checks for the argument tokenizer, bound to the top level.
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_macros.svh"

module qat_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);
  import qat_pkg::*;

  logic end_on_sep;

  // data byte is a separator: space or quote
  assign end_on_sep = (m_tdata == CH_SPACE) || (m_tdata == CH_QUOTE);

  // a stalled result word holds
  `QAT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

  // no token byte means a zero data field
  `QAT_ASSERT_NOW(a_zero_char, m_tvalid && !m_tuser[0], m_tdata == 8'h00)

  // a drop never comes with both a byte and a token end
  `QAT_ASSERT_NOW(a_drop_mix, m_tvalid && m_tuser[1], !(m_tuser[0] && m_tlast))

  // a byte that closes its token is a plain byte, never space or quote
  `QAT_ASSERT_NOW(a_end_char, m_tvalid && m_tlast && m_tuser[0], !end_on_sep)

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (.*);
